@@ src/ws2812_spi_bit_encoder_macros.svh @@
// assertion macros for the ws2812 spi bit encoder
`ifndef WS2812_SPI_BIT_ENCODER_MACROS_SVH
`define WS2812_SPI_BIT_ENCODER_MACROS_SVH

// property that holds on every clock edge out of reset
`define WSE_ASSERT(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// trigger on one edge implies a condition on the next edge
`define WSE_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) else $error(msg);

`endif

@@ src/wse_pkg.sv @@
// types, constants and the nibble encoder of the ws2812 spi bit encoder
package wse_pkg;

    localparam int COLOR_W     = 24;
    localparam int WORD_W      = 16;
    localparam int LED_COUNT_W = 11;
    localparam int RESET_SL_W  = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int NIBBLE_W    = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_SLOTS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAPPED_ORDER = 2'd2;

    // input operation codes
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_START   = 1'b1;

    // line patterns for one data bit
    localparam logic [NIBBLE_W-1:0] LINE_ONE  = 4'b1110;
    localparam logic [NIBBLE_W-1:0] LINE_ZERO = 4'b1000;

    // result flags, exactly one set per result
    typedef struct packed {
        logic in_reset_gap;
        logic led_encoded;
        logic frame_done;
    } t_flags;

    // four colour bits become sixteen line bits, msb first
    function automatic logic [WORD_W-1:0] encode_nibble(input logic [NIBBLE_W-1:0] nib);
        logic [WORD_W-1:0] word;
        word = '0;
        for (int b = NIBBLE_W - 1; b >= 0; b--) begin
            word = {word[WORD_W-NIBBLE_W-1:0], (nib[b] ? LINE_ONE : LINE_ZERO)};
        end
        return word;
    endfunction

endpackage

@@ src/ws2812_spi_bit_encoder.sv @@
// ws2812 spi bit encoder: slot sequencing and colour to line bit expansion
// an accepted advance transaction has its result registered and shown in the next cycle
// throughput: one transaction per cycle while results are taken; the result register frees as it is taken
// a start transaction updates the slot position only and gives no result
// reset (synchronous, active low) clears the result valid, loads the register
// defaults and parks the slot position at zero, so the frame reads as done
module ws2812_spi_bit_encoder
    import wse_pkg::*;
#(
    parameter int MAX_LEDS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_operation,
    input  logic [COLOR_W-1:0]     i_color,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [WORD_W-1:0]      o_word_a,
    output logic [WORD_W-1:0]      o_word_b,
    output logic [WORD_W-1:0]      o_word_c,
    output logic [WORD_W-1:0]      o_word_d,
    output logic [WORD_W-1:0]      o_word_e,
    output logic [WORD_W-1:0]      o_word_f,
    output logic                   o_in_reset_gap,
    output logic                   o_led_encoded,
    output logic                   o_frame_done
);

    localparam int CNT_W = $clog2(MAX_LEDS + 1);
    localparam int POS_W = ((CNT_W > RESET_SL_W) ? CNT_W : RESET_SL_W) + 1;

    logic [CNT_W-1:0]      r_led_count;
    logic [RESET_SL_W-1:0] r_reset_slots;
    logic                  r_swapped;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_out_valid, n_out_valid;
    logic [WORD_W-1:0]     r_word_a, r_word_b, r_word_c, r_word_d, r_word_e, r_word_f;
    logic [WORD_W-1:0]     n_word_a, n_word_b, n_word_c, n_word_d, n_word_e, n_word_f;
    t_flags                r_flags, n_flags;

    logic                  w_in_acc;
    logic [POS_W-1:0]      w_count_ext;
    logic [POS_W-1:0]      w_gap_ext;
    logic                  w_pos_neg;
    logic                  w_pos_below;
    logic [NIBBLE_W-1:0]   w_nib_a, w_nib_b, w_nib_c, w_nib_d;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_count_ext = {{(POS_W-CNT_W){1'b0}}, r_led_count};
    assign w_gap_ext   = {{(POS_W-RESET_SL_W){1'b0}}, r_reset_slots};
    assign w_pos_neg   = r_pos[POS_W-1];
    assign w_pos_below = $signed(r_pos) < $signed(w_count_ext);

    // swapped order sends the middle byte's nibbles first
    assign w_nib_a = r_swapped ? i_color[15:12] : i_color[23:20];
    assign w_nib_b = r_swapped ? i_color[11:8]  : i_color[19:16];
    assign w_nib_c = r_swapped ? i_color[23:20] : i_color[15:12];
    assign w_nib_d = r_swapped ? i_color[19:16] : i_color[11:8];

    always_comb begin
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_flags     = r_flags;
        n_word_a    = r_word_a;
        n_word_b    = r_word_b;
        n_word_c    = r_word_c;
        n_word_d    = r_word_d;
        n_word_e    = r_word_e;
        n_word_f    = r_word_f;
        if (w_in_acc) begin
            case (i_operation)
                OP_START: begin
                    n_pos = POS_W'(-$signed(w_gap_ext));
                end
                OP_ADVANCE: begin
                    n_out_valid = 1'b1;
                    n_flags     = '0;
                    n_word_a    = '0;
                    n_word_b    = '0;
                    n_word_c    = '0;
                    n_word_d    = '0;
                    n_word_e    = '0;
                    n_word_f    = '0;
                    if (w_pos_neg) begin
                        n_flags.in_reset_gap = 1'b1;
                        n_pos = r_pos + POS_W'(1);
                    end else if (w_pos_below) begin
                        n_flags.led_encoded = 1'b1;
                        n_word_a = encode_nibble(w_nib_a);
                        n_word_b = encode_nibble(w_nib_b);
                        n_word_c = encode_nibble(w_nib_c);
                        n_word_d = encode_nibble(w_nib_d);
                        n_word_e = encode_nibble(i_color[7:4]);
                        n_word_f = encode_nibble(i_color[3:0]);
                        n_pos = r_pos + POS_W'(1);
                    end else begin
                        // past the last led the position holds
                        n_flags.frame_done = 1'b1;
                    end
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count   <= '0;
            r_reset_slots <= RESET_SL_W'(2);
            r_swapped     <= 1'b0;
            r_pos         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LED_COUNT: begin
                        // oversized counts saturate
                        if (i_cfg_data[LED_COUNT_W-1:0] > LED_COUNT_W'(MAX_LEDS)) begin
                            r_led_count <= CNT_W'(MAX_LEDS);
                        end else begin
                            r_led_count <= CNT_W'(i_cfg_data[LED_COUNT_W-1:0]);
                        end
                    end
                    CFG_RESET_SLOTS: begin
                        r_reset_slots <= i_cfg_data[RESET_SL_W-1:0];
                    end
                    CFG_SWAPPED_ORDER: begin
                        r_swapped <= i_cfg_data[0];
                    end
                    default: begin
                        r_swapped <= r_swapped;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags  <= n_flags;
        r_word_a <= n_word_a;
        r_word_b <= n_word_b;
        r_word_c <= n_word_c;
        r_word_d <= n_word_d;
        r_word_e <= n_word_e;
        r_word_f <= n_word_f;
    end

    assign o_out_valid    = r_out_valid;
    assign o_word_a       = r_word_a;
    assign o_word_b       = r_word_b;
    assign o_word_c       = r_word_c;
    assign o_word_d       = r_word_d;
    assign o_word_e       = r_word_e;
    assign o_word_f       = r_word_f;
    assign o_in_reset_gap = r_flags.in_reset_gap;
    assign o_led_encoded  = r_flags.led_encoded;
    assign o_frame_done   = r_flags.frame_done;

`include "ws2812_spi_bit_encoder_macros.svh"

    `WSE_ASSERT(a_flags_onehot, !r_out_valid || $onehot(r_flags), "result flags not one-hot")
    `WSE_ASSERT(a_words_zero, !r_out_valid || r_flags.led_encoded || ((r_word_a | r_word_b | r_word_c | r_word_d | r_word_e | r_word_f) == '0), "non-led result has nonzero words")
    `WSE_ASSERT_NEXT(a_gap_follows, w_in_acc && (i_operation == OP_ADVANCE) && w_pos_neg, r_out_valid && r_flags.in_reset_gap, "negative position did not give a reset gap")
    `WSE_ASSERT_NEXT(a_start_silent, w_in_acc && (i_operation == OP_START) && i_out_ready, !r_out_valid, "start transaction produced a result")

endmodule
